### rtl/ptes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptes_pkg
// Shared types, codes and helpers of the priority timed event scheduler.
// ----------------------------------------------------------------------------
package ptes_pkg;

  // table geometry
  localparam int unsigned MaxHandlers = 16;
  localparam int unsigned CntW        = $clog2(MaxHandlers + 1);
  localparam int unsigned StepW       = $clog2(MaxHandlers);

  // field widths
  localparam int unsigned IdW   = 8;
  localparam int unsigned PrioW = 8;
  localparam int unsigned SecW  = 32;
  localparam int unsigned NsecW = 30;

  // reset value of the horizon register, one day in seconds
  localparam logic [SecW-1:0] HorizonReset = SecW'(24 * 60 * 60);

  // input opcodes
  localparam logic [2:0] OpClear    = 3'd0;
  localparam logic [2:0] OpAdd      = 3'd1;
  localparam logic [2:0] OpSetAct   = 3'd2;
  localparam logic [2:0] OpQuery    = 3'd3;
  localparam logic [2:0] OpDispatch = 3'd4;

  // result kinds
  localparam logic [2:0] KindDone    = 3'd0;
  localparam logic [2:0] KindFull    = 3'd1;
  localparam logic [2:0] KindTimeout = 3'd2;
  localparam logic [2:0] KindEmpty   = 3'd3;
  localparam logic [2:0] KindDue     = 3'd4;
  localparam logic [2:0] KindNone    = 3'd5;

  // one table entry
  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
    logic [SecW-1:0]  sec;
    logic [NsecW-1:0] nsec;
  } entry_t;

  // what every cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SET,
    CELL_ROTATE
  } cell_op_e;

  // command broadcast to the whole row
  typedef struct packed {
    cell_op_e op;
    entry_t   ent;
  } cell_cmd_t;

  // seconds first, then nanoseconds
  function automatic logic time_before(input logic [SecW-1:0]  a_sec,
                                       input logic [NsecW-1:0] a_nsec,
                                       input logic [SecW-1:0]  b_sec,
                                       input logic [NsecW-1:0] b_nsec);
    time_before = (a_sec < b_sec) || ((a_sec == b_sec) && (a_nsec < b_nsec));
  endfunction

endpackage

### rtl/ptes_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptes_cell
// One slot of the handler table: keeps, inserts, updates or rotates an entry.
// ----------------------------------------------------------------------------
module ptes_cell (
  input  logic                cell_clk_i,
  input  ptes_pkg::cell_cmd_t cmd_i,
  input  logic                valid_i,
  input  logic                pass_prev_i,
  input  ptes_pkg::entry_t    prev_i,
  input  ptes_pkg::entry_t    next_i,
  output ptes_pkg::entry_t    entry_o,
  output logic                pass_o
);

  ptes_pkg::entry_t ent_q, ent_d;

  // entry stays ahead of a new one of lower or equal priority
  assign pass_o  = valid_i && (ent_q.prio >= cmd_i.ent.prio);
  assign entry_o = ent_q;

  // next entry value
  always_comb begin
    ent_d = ent_q;
    case (cmd_i.op)
      ptes_pkg::CELL_INSERT: begin
        if (!pass_o) begin
          ent_d = pass_prev_i ? cmd_i.ent : prev_i;
        end
      end
      ptes_pkg::CELL_SET: begin
        if (valid_i && (ent_q.id == cmd_i.ent.id)) begin
          ent_d.sec  = cmd_i.ent.sec;
          ent_d.nsec = cmd_i.ent.nsec;
        end
      end
      ptes_pkg::CELL_ROTATE: begin
        ent_d = next_i;
      end
      default: begin
        ent_d = ent_q;
      end
    endcase
  end

  always_ff @(posedge cell_clk_i) begin
    ent_q <= ent_d;
  end

endmodule

### rtl/priority_timed_event_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_timed_event_scheduler_unit
// Handler table in priority order with activation times, timeout and dispatch.
// ----------------------------------------------------------------------------
// Usage:
//   One operation per input transaction (in_valid_i / in_stall_o): clear, add
//   handler, set activation, query next timeout, dispatch. Results leave on
//   the output channel (out_valid_o / out_stall_i), last_o marks the final
//   result of an operation. The horizon register is written over APB.
// Timing:
//   The table is a row of 16 cells. Clear, add and set activation give their
//   result from the exec state that follows acceptance. Query and dispatch
//   rotate the whole row once past the head cell, one entry a cycle while
//   dispatch is not paused for the receiver. One operation is in flight at a
//   time; in_stall_o is high until its last result is loaded into the output
//   register, which then may still wait for the receiver.
// Reset:
//   The table is empty and the horizon is one day. Entry contents are not
//   cleared, only the fill count.
// Stall:
//   A stalled result holds its value; dispatch pauses its rotation while a
//   further due handler cannot be handed over.
// ----------------------------------------------------------------------------
module priority_timed_event_scheduler_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  handler_id_i,
  input  logic [7:0]  priority_req_i,
  input  logic [31:0] time_sec_i,
  input  logic [29:0] time_nsec_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  due_id_o,
  output logic [31:0] timeout_sec_o,
  output logic [29:0] timeout_nsec_o,
  output logic        last_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned N     = ptes_pkg::MaxHandlers;
  localparam int unsigned CntW  = ptes_pkg::CntW;
  localparam int unsigned StepW = ptes_pkg::StepW;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StExec = 2'd1;
  localparam logic [1:0] StScan = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [StepW-1:0] step_q, step_d;
  logic [31:0]      horizon_q;

  logic [2:0]       op_q;
  ptes_pkg::entry_t req_q;
  logic [31:0]      min_sec_q, min_sec_d;
  logic [29:0]      min_nsec_q, min_nsec_d;
  logic             pend_valid_q, pend_valid_d;
  logic [7:0]       pend_id_q, pend_id_d;

  logic             out_valid_q, out_valid_d;
  logic [2:0]       kind_q, kind_d;
  logic [7:0]       due_id_q, due_id_d;
  logic [31:0]      tsec_q, tsec_d;
  logic [29:0]      tnsec_q, tnsec_d;
  logic             last_q, last_d;
  logic             emit;

  ptes_pkg::cell_op_e  cell_op;
  ptes_pkg::cell_cmd_t cmd;
  ptes_pkg::entry_t    cell_ent [N];
  logic [N-1:0]        cell_pass;
  logic [N-1:0]        cell_valid;
  ptes_pkg::entry_t    head;

  logic        accept;
  logic        out_free;
  logic        active;
  logic        due;
  logic [32:0] cap_sum;
  logic        cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? horizon_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      horizon_q <= ptes_pkg::HorizonReset;
    end else if (cfg_wr) begin
      horizon_q <= pwdata;
    end
  end

  // handshakes
  assign in_stall_o  = (state_q != StIdle);
  assign accept      = in_valid_i && (state_q == StIdle);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign kind_o         = kind_q;
  assign due_id_o       = due_id_q;
  assign timeout_sec_o  = tsec_q;
  assign timeout_nsec_o = tnsec_q;
  assign last_o         = last_q;

  // timeout cap: now plus horizon, seconds saturate
  assign cap_sum = {1'b0, time_sec_i} + {1'b0, horizon_q};

  // row of cells
  assign head = cell_ent[0];
  assign cmd  = {cell_op, req_q};

  for (genvar g = 0; g < N; g++) begin : g_cell
    assign cell_valid[g] = (count_q > CntW'(g));
    ptes_cell u_cell (
      .cell_clk_i  (clk_i),
      .cmd_i       (cmd),
      .valid_i     (cell_valid[g]),
      .pass_prev_i ((g == 0) ? 1'b1 : cell_pass[(g + N - 1) % N]),
      .prev_i      (cell_ent[(g + N - 1) % N]),
      .next_i      (cell_ent[(g + 1) % N]),
      .entry_o     (cell_ent[g]),
      .pass_o      (cell_pass[g])
    );
  end

  // scan qualifiers
  assign active = ({1'b0, step_q} < count_q);
  assign due    = active && ptes_pkg::time_before(head.sec, head.nsec,
                                                  req_q.sec, req_q.nsec);

  // sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    step_d       = step_q;
    min_sec_d    = min_sec_q;
    min_nsec_d   = min_nsec_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    cell_op      = ptes_pkg::CELL_HOLD;
    emit         = 1'b0;
    kind_d       = ptes_pkg::KindDone;
    due_id_d     = '0;
    tsec_d       = '0;
    tnsec_d      = '0;
    last_d       = 1'b1;

    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d      = StExec;
          step_d       = '0;
          pend_valid_d = 1'b0;
          min_sec_d    = cap_sum[32] ? '1 : cap_sum[31:0];
          min_nsec_d   = time_nsec_i;
        end
      end
      StExec: begin
        case (op_q)
          ptes_pkg::OpClear: begin
            if (out_free) begin
              count_d = '0;
              emit    = 1'b1;
              state_d = StIdle;
            end
          end
          ptes_pkg::OpAdd: begin
            if (out_free) begin
              emit    = 1'b1;
              state_d = StIdle;
              if (count_q == CntW'(N)) begin
                kind_d = ptes_pkg::KindFull;
              end else begin
                cell_op = ptes_pkg::CELL_INSERT;
                count_d = count_q + CntW'(1);
              end
            end
          end
          ptes_pkg::OpSetAct: begin
            if (out_free) begin
              cell_op = ptes_pkg::CELL_SET;
              emit    = 1'b1;
              state_d = StIdle;
            end
          end
          ptes_pkg::OpQuery: begin
            if (count_q == '0) begin
              if (out_free) begin
                kind_d  = ptes_pkg::KindEmpty;
                emit    = 1'b1;
                state_d = StIdle;
              end
            end else begin
              state_d = StScan;
            end
          end
          ptes_pkg::OpDispatch: begin
            state_d = StScan;
          end
          default: begin
            if (out_free) begin
              emit    = 1'b1;
              state_d = StIdle;
            end
          end
        endcase
      end
      StScan: begin
        if (op_q == ptes_pkg::OpQuery) begin
          // running minimum over the head cell
          cell_op = ptes_pkg::CELL_ROTATE;
          if (active && ptes_pkg::time_before(head.sec, head.nsec,
                                              min_sec_q, min_nsec_q)) begin
            min_sec_d  = head.sec;
            min_nsec_d = head.nsec;
          end
          step_d = step_q + StepW'(1);
          if (step_q == StepW'(N - 1)) begin
            state_d = StFin;
          end
        end else if (!(due && pend_valid_q && !out_free)) begin
          // hold back one due handler so the final one can carry last
          cell_op = ptes_pkg::CELL_ROTATE;
          if (due) begin
            if (pend_valid_q) begin
              emit     = 1'b1;
              kind_d   = ptes_pkg::KindDue;
              due_id_d = pend_id_q;
              last_d   = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_id_d    = head.id;
          end
          step_d = step_q + StepW'(1);
          if (step_q == StepW'(N - 1)) begin
            state_d = StFin;
          end
        end
      end
      StFin: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = StIdle;
          if (op_q == ptes_pkg::OpQuery) begin
            kind_d = ptes_pkg::KindTimeout;
            if (ptes_pkg::time_before(min_sec_q, min_nsec_q,
                                      req_q.sec, req_q.nsec)) begin
              tsec_d  = req_q.sec;
              tnsec_d = req_q.nsec;
            end else begin
              tsec_d  = min_sec_q;
              tnsec_d = min_nsec_q;
            end
          end else if (pend_valid_q) begin
            kind_d   = ptes_pkg::KindDue;
            due_id_d = pend_id_q;
          end else begin
            kind_d = ptes_pkg::KindNone;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // output register valid
  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      count_q      <= '0;
      step_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      step_q       <= step_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // transaction and working payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= opcode_i;
      req_q.id   <= handler_id_i;
      req_q.prio <= priority_req_i;
      req_q.sec  <= time_sec_i;
      req_q.nsec <= time_nsec_i;
    end
    min_sec_q  <= min_sec_d;
    min_nsec_q <= min_nsec_d;
    pend_id_q  <= pend_id_d;
    if (emit) begin
      kind_q   <= kind_d;
      due_id_q <= due_id_d;
      tsec_q   <= tsec_d;
      tnsec_q  <= tnsec_d;
      last_q   <= last_d;
    end
  end

endmodule

### dv/priority_timed_event_scheduler_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_timed_event_scheduler_unit_test
// Checks the handler table against a cycle-free software view of the table.
// Each accepted operation updates the local table copy and queues the
// results it should cause; every result leaving the unit is compared field
// by field. Runs directed corner cases, then random operation sequences under
// three horizon settings; both channels idle at random but in the first.
// ----------------------------------------------------------------------------
module priority_timed_event_scheduler_unit_test;
  import ptes_pkg::*;

  localparam int unsigned     CycleLimit    = 200_000;
  localparam int unsigned     HoldCycles    = 300;
  localparam int unsigned     DrainCycles   = 40;
  localparam int unsigned     MaxPrinted    = 40;
  localparam logic [2:0]      AddrHorizon   = 3'd0;
  localparam logic [2:0]      OpFirstUnused = 3'd5;
  localparam logic [2:0]      OpLastUnused  = 3'd7;
  localparam logic [SecW-1:0] SecMax        = 32'hFFFF_FFFF;
  localparam logic [NsecW-1:0] NsecMax      = 30'h3FFF_FFFF;
  localparam logic [NsecW-1:0] NsecTop      = 30'd999_999_999;

  // one operation transaction
  typedef struct {
    logic [2:0]       opcode;
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
    logic [SecW-1:0]  sec;
    logic [NsecW-1:0] nsec;
  } sched_op_t;

  // one result transaction
  typedef struct {
    logic [2:0]       kind;
    logic [IdW-1:0]   due_id;
    logic [SecW-1:0]  tsec;
    logic [NsecW-1:0] tnsec;
    logic             last;
  } sched_result_t;

  // dut ports
  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_stall_o;
  logic [2:0]        opcode_i       = '0;
  logic [IdW-1:0]    handler_id_i   = '0;
  logic [PrioW-1:0]  priority_req_i = '0;
  logic [SecW-1:0]   time_sec_i     = '0;
  logic [NsecW-1:0]  time_nsec_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i    = 1'b0;
  logic [2:0]        kind_o;
  logic [IdW-1:0]    due_id_o;
  logic [SecW-1:0]   timeout_sec_o;
  logic [NsecW-1:0]  timeout_nsec_o;
  logic              last_o;
  logic              psel           = 1'b0;
  logic              penable        = 1'b0;
  logic              pwrite         = 1'b0;
  logic [2:0]        paddr          = '0;
  logic [31:0]       pwdata         = '0;
  logic [31:0]       prdata;
  logic              pready;

  // local copy of the handler table and the horizon register
  logic [IdW-1:0]    tbl_id   [MaxHandlers];
  logic [PrioW-1:0]  tbl_prio [MaxHandlers];
  logic [SecW-1:0]   tbl_sec  [MaxHandlers];
  logic [NsecW-1:0]  tbl_nsec [MaxHandlers];
  int unsigned       tbl_count = 0;
  logic [SecW-1:0]   horizon   = HorizonReset;

  sched_op_t         op_queue[$];
  sched_result_t     awaited_results[$];
  sched_op_t         drv_op;
  sched_result_t     chk_exp;
  logic              drv_busy = 1'b0;
  int unsigned       tx_gap   = 0;
  int unsigned       rx_wait  = 0;
  logic              rx_hold  = 1'b0;
  logic              hold_arm = 1'b0;
  logic              idle_en  = 1'b1;

  int unsigned       ops_pushed   = 0;
  int unsigned       ops_accepted = 0;
  int unsigned       results_seen = 0;
  int unsigned       err_cnt      = 0;
  int unsigned       cycle_cnt    = 0;
  int unsigned       cfg_writes   = 0;
  int unsigned       due_seen     = 0;
  int unsigned       full_seen    = 0;
  int unsigned       timeout_seen = 0;
  int unsigned       quiet_seen   = 0;

  priority_timed_event_scheduler_unit u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .opcode_i,
    .handler_id_i,
    .priority_req_i,
    .time_sec_i,
    .time_nsec_i,
    .out_valid_o,
    .out_stall_i,
    .kind_o,
    .due_id_o,
    .timeout_sec_o,
    .timeout_nsec_o,
    .last_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // seconds first, then nanoseconds
  function automatic logic earlier(input logic [SecW-1:0] a_s, input logic [NsecW-1:0] a_n,
                                   input logic [SecW-1:0] b_s, input logic [NsecW-1:0] b_n);
    return (a_s < b_s) || ((a_s == b_s) && (a_n < b_n));
  endfunction

  function automatic void push_result(input logic [2:0] kind, input logic [IdW-1:0] id,
                                      input logic [SecW-1:0] s, input logic [NsecW-1:0] n,
                                      input logic last);
    sched_result_t r;
    r.kind   = kind;
    r.due_id = id;
    r.tsec   = s;
    r.tnsec  = n;
    r.last   = last;
    awaited_results.push_back(r);
  endfunction

  // apply one operation to the table copy and queue the results it causes
  function automatic void compute_results(input sched_op_t op);
    int unsigned      pos;
    int unsigned      due_cnt;
    logic [SecW:0]    sum;
    logic [SecW-1:0]  best_s;
    logic [NsecW-1:0] best_n;
    case (op.opcode)
      OpClear: begin
        tbl_count = 0;
        push_result(KindDone, '0, '0, '0, 1'b1);
      end
      OpAdd: begin
        if (tbl_count >= MaxHandlers) begin
          push_result(KindFull, '0, '0, '0, 1'b1);
        end else begin
          // new entry goes after every entry of equal or higher priority
          pos = 0;
          while (pos < tbl_count && tbl_prio[pos] >= op.prio) pos++;
          for (int unsigned i = tbl_count; i > pos; i--) begin
            tbl_id[i]   = tbl_id[i-1];
            tbl_prio[i] = tbl_prio[i-1];
            tbl_sec[i]  = tbl_sec[i-1];
            tbl_nsec[i] = tbl_nsec[i-1];
          end
          tbl_id[pos]   = op.id;
          tbl_prio[pos] = op.prio;
          tbl_sec[pos]  = op.sec;
          tbl_nsec[pos] = op.nsec;
          tbl_count++;
          push_result(KindDone, '0, '0, '0, 1'b1);
        end
      end
      OpSetAct: begin
        // every entry carrying the id is updated
        for (int unsigned i = 0; i < tbl_count; i++) begin
          if (tbl_id[i] == op.id) begin
            tbl_sec[i]  = op.sec;
            tbl_nsec[i] = op.nsec;
          end
        end
        push_result(KindDone, '0, '0, '0, 1'b1);
      end
      OpQuery: begin
        if (tbl_count == 0) begin
          push_result(KindEmpty, '0, '0, '0, 1'b1);
        end else begin
          // start from the capped horizon, seconds saturate
          sum    = {1'b0, op.sec} + {1'b0, horizon};
          best_s = sum[SecW] ? SecMax : sum[SecW-1:0];
          best_n = op.nsec;
          for (int unsigned i = 0; i < tbl_count; i++) begin
            if (earlier(tbl_sec[i], tbl_nsec[i], best_s, best_n)) begin
              best_s = tbl_sec[i];
              best_n = tbl_nsec[i];
            end
          end
          // never report a timeout in the past
          if (earlier(best_s, best_n, op.sec, op.nsec)) begin
            best_s = op.sec;
            best_n = op.nsec;
          end
          push_result(KindTimeout, '0, best_s, best_n, 1'b1);
        end
      end
      OpDispatch: begin
        due_cnt = 0;
        for (int unsigned i = 0; i < tbl_count; i++) begin
          if (earlier(tbl_sec[i], tbl_nsec[i], op.sec, op.nsec)) begin
            push_result(KindDue, tbl_id[i], '0, '0, 1'b0);
            due_cnt++;
          end
        end
        if (due_cnt == 0) push_result(KindNone, '0, '0, '0, 1'b1);
        else awaited_results[awaited_results.size()-1].last = 1'b1;
      end
      default: begin
        push_result(KindDone, '0, '0, '0, 1'b1);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_cnt < MaxPrinted)
      $display("[%0t] mismatch: %s got 0x%0h want 0x%0h (result %0d)",
               $realtime, what, got, want, results_seen);
    err_cnt++;
  endtask

  // driver: offers queued operations after a random gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      drv_busy = 1'b0;
      tx_gap   = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        compute_results(drv_op);
        ops_accepted++;
        drv_busy = 1'b0;
        tx_gap   = idle_en ? $urandom_range(0, 6) : 0;
      end
      if (!drv_busy) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (op_queue.size() > 0) begin
          drv_op = op_queue.pop_front();
          drv_busy = 1'b1;
          opcode_i       <= drv_op.opcode;
          handler_id_i   <= drv_op.id;
          priority_req_i <= drv_op.prio;
          time_sec_i     <= drv_op.sec;
          time_nsec_i    <= drv_op.nsec;
        end
      end
      in_valid_i <= drv_busy;
    end
  end

  // monitor: checks each result transaction and stalls at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          report_mismatch("result with nothing pending, kind", 32'(kind_o), '0);
        end else begin
          chk_exp = awaited_results.pop_front();
          if (kind_o !== chk_exp.kind)
            report_mismatch("kind", 32'(kind_o), 32'(chk_exp.kind));
          if (due_id_o !== chk_exp.due_id)
            report_mismatch("due_id", 32'(due_id_o), 32'(chk_exp.due_id));
          if (timeout_sec_o !== chk_exp.tsec)
            report_mismatch("timeout_sec", timeout_sec_o, chk_exp.tsec);
          if (timeout_nsec_o !== chk_exp.tnsec)
            report_mismatch("timeout_nsec", 32'(timeout_nsec_o), 32'(chk_exp.tnsec));
          if (last_o !== chk_exp.last)
            report_mismatch("last", 32'(last_o), 32'(chk_exp.last));
        end
        case (kind_o)
          KindDue:            due_seen++;
          KindFull:           full_seen++;
          KindTimeout:        timeout_seen++;
          KindEmpty, KindNone: quiet_seen++;
          default: ;
        endcase
        rx_wait = idle_en ? $urandom_range(0, 6) : 0;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall_i <= rx_hold || (rx_wait > 0);
    end
  end

  // long receiver hold-off so the unit backs up into its input
  initial begin
    wait (hold_arm);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_op(input logic [2:0] opc, input logic [IdW-1:0] id,
                         input logic [PrioW-1:0] prio, input logic [SecW-1:0] s,
                         input logic [NsecW-1:0] n);
    sched_op_t op;
    op.opcode = opc;
    op.id     = id;
    op.prio   = prio;
    op.sec    = s;
    op.nsec   = n;
    op_queue.push_back(op);
    ops_pushed++;
  endtask

  function automatic logic [NsecW-1:0] rand_nsec();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 30'd1;
      2: return NsecTop;
      3: return NsecMax;
      4: return 30'd500_000_000;
      default: return 30'($urandom_range(0, 999_999_999));
    endcase
  endfunction

  function automatic logic [SecW-1:0] rand_base();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return SecMax - 32'd7;
      default: return $urandom_range(8, 32'hFFFF_FF00);
    endcase
  endfunction

  // small id pool so set activation and duplicates hit often
  function automatic logic [IdW-1:0] rand_id();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
  endfunction

  // few distinct priorities so ties are common
  function automatic logic [PrioW-1:0] rand_prio();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 8'hFF;
      2: return 8'($urandom);
      default: return 8'($urandom_range(1, 3));
    endcase
  endfunction

  // clear, a burst of adds, then mixed traffic around one point in time
  task automatic push_random_ops(input int unsigned n_ops);
    logic [SecW-1:0] base;
    int unsigned     made;
    int unsigned     r;
    made = 0;
    while (made < n_ops) begin
      base = rand_base();
      push_op(OpClear, 8'($urandom), 8'($urandom), $urandom, 30'($urandom));
      made++;
      repeat ($urandom_range(2, 18)) begin
        push_op(OpAdd, rand_id(), rand_prio(), base + $urandom_range(0, 6), rand_nsec());
        made++;
      end
      repeat ($urandom_range(8, 20)) begin
        r = $urandom_range(0, 99);
        if (r < 8)
          push_op(3'($urandom), 8'($urandom), 8'($urandom), $urandom, 30'($urandom));
        else if (r < 28)
          push_op(OpAdd, rand_id(), rand_prio(), base + $urandom_range(0, 6), rand_nsec());
        else if (r < 45)
          push_op(OpSetAct, rand_id(), 8'($urandom), base + $urandom_range(0, 6), rand_nsec());
        else if (r < 65)
          push_op(OpQuery, 8'($urandom), 8'($urandom), base + $urandom_range(0, 7), rand_nsec());
        else if (r < 94)
          push_op(OpDispatch, 8'($urandom), 8'($urandom), base + $urandom_range(0, 7),
                  rand_nsec());
        else
          push_op(OpClear, 8'($urandom), 8'($urandom), $urandom, 30'($urandom));
        made++;
      end
    end
  endtask

  // all operations taken and every result returned
  task automatic wait_idle();
    while (ops_accepted != ops_pushed || awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrHorizon;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    horizon = value;
    cfg_writes++;
  endtask

  // stimulus sequence
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners at the reset horizon
    push_op(OpQuery, 8'd0, 8'd0, '0, '0);
    push_op(OpDispatch, 8'hFF, 8'hFF, SecMax, NsecMax);
    push_op(OpAdd, 8'd5, 8'd10, 32'd100, 30'd500);
    push_op(OpAdd, 8'd6, 8'd10, 32'd100, 30'd400);
    push_op(OpAdd, 8'd7, 8'hFF, 32'd50, 30'd0);
    push_op(OpAdd, 8'd8, 8'd0, SecMax, NsecMax);
    push_op(OpAdd, 8'd5, 8'd3, 32'd200, 30'd0);
    push_op(OpSetAct, 8'd5, 8'd0, 32'd99, NsecTop);
    push_op(OpSetAct, 8'd200, 8'd0, 32'd1, 30'd1);
    push_op(OpQuery, 8'd0, 8'd0, 32'd40, 30'd0);
    push_op(OpQuery, 8'd0, 8'd0, 32'd99, 30'd0);
    push_op(OpDispatch, 8'd0, 8'd0, 32'd100, 30'd400);
    push_op(OpFirstUnused, 8'hFF, 8'hFF, SecMax, NsecMax);
    push_op(OpLastUnused, 8'hFF, 8'hFF, SecMax, NsecMax);
    for (int i = 0; i < 11; i++)
      push_op(OpAdd, 8'(20 + i), 8'($urandom), $urandom_range(0, 1000), rand_nsec());
    push_op(OpAdd, 8'd99, 8'd1, 32'd1, 30'd1);
    push_op(OpDispatch, 8'd0, 8'd0, SecMax, NsecMax);
    wait_idle();

    // smallest horizon, no idling on either side
    apb_write(32'd1);
    idle_en = 1'b0;
    push_op(OpClear, 8'd0, 8'd0, '0, '0);
    push_op(OpAdd, 8'd1, 8'd1, 32'd1000, 30'd5);
    push_op(OpQuery, 8'd0, 8'd0, 32'd10, 30'd7);
    push_random_ops(40);
    wait_idle();

    // largest horizon, seconds saturate; receiver holds off for a while
    apb_write(SecMax);
    idle_en = 1'b1;
    push_op(OpClear, 8'd0, 8'd0, '0, '0);
    push_op(OpAdd, 8'd2, 8'd9, SecMax, NsecMax);
    push_op(OpQuery, 8'd0, 8'd0, SecMax - 32'd5, 30'd3);
    push_random_ops(40);
    hold_arm = 1'b1;
    wait_idle();

    // a short random horizon
    apb_write($urandom_range(2, 10));
    push_random_ops(40);
    wait_idle();

    // let any stray result show up
    repeat (DrainCycles) @(posedge clk_i);
    if (awaited_results.size() != 0)
      report_mismatch("results never returned", awaited_results.size(), '0);

    $display("covered %0d operations and %0d results under %0d horizon writes",
             ops_accepted, results_seen, cfg_writes);
    $display("due handlers %0d, table full %0d, timeouts %0d, empty or none due %0d",
             due_seen, full_seen, timeout_seen, quiet_seen);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
